// File: hdl/kdee_pkg.sv
package kdee_pkg;
  localparam int NUM_KEYS_DEF  = 22;
  localparam int SCAN_BITS_DEF = 24;
  localparam int COMBO_MAX_DEF = 5;
  localparam int TIME_BITS_DEF = 32;
  localparam int OUT_BITS      = 22;
  localparam int CNT_BITS      = 5;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int MS_BITS       = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG      = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RPT_DELAY = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RPT_PER   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RPT_EN    = 3'd4;

  // scan bit position of key k (zero based)
  function automatic int unsigned key_bit(input int unsigned k);
    int unsigned r;
    r = ((k / 8) * 8) + 7 - (k % 8);
    return r;
  endfunction
endpackage

// File: hdl/kdee_in_if.sv
interface kdee_in_if #(parameter int TIME_BITS = 32, parameter int SCAN_BITS = 24);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] now_ms;
  logic [SCAN_BITS-1:0] scan_word;
  modport source (output valid, now_ms, scan_word, input ready);
  modport sink   (input valid, now_ms, scan_word, output ready);
endinterface

// File: hdl/kdee_out_if.sv
interface kdee_out_if;
  logic        valid;
  logic        ready;
  logic [21:0] press_mask;
  logic [21:0] release_mask;
  logic [21:0] long_mask;
  logic [21:0] repeat_mask;
  logic        combo_valid;
  logic [4:0]  combo_first_key;
  logic [4:0]  held_count;
  logic [21:0] held_mask;
  modport source (output valid, press_mask, release_mask, long_mask, repeat_mask,
                  combo_valid, combo_first_key, held_count, held_mask, input ready);
  modport sink   (input valid, press_mask, release_mask, long_mask, repeat_mask,
                  combo_valid, combo_first_key, held_count, held_mask, output ready);
endinterface

// File: hdl/kdee_cfg_if.sv
interface kdee_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/kdee_ram.sv
module kdee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/kdee_keyseq.sv
// Per-key walk over the key state memory: one key at a time, read, update, write back.
module kdee_keyseq
  import kdee_pkg::*;
#(
  parameter int NUM_KEYS  = NUM_KEYS_DEF,
  parameter int SCAN_BITS = SCAN_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 edge_upd,
  input  logic [SCAN_BITS-1:0] stable_word,
  input  logic [TIME_BITS-1:0] now,
  input  logic [MS_BITS-1:0]   long_ms,
  input  logic [MS_BITS-1:0]   rpt_delay_ms,
  input  logic [MS_BITS-1:0]   rpt_period_ms,
  input  logic [OUT_BITS-1:0]  rpt_en,
  input  logic [NUM_KEYS-1:0]  down_q,
  output logic [NUM_KEYS-1:0]  down_d,
  output logic                 done,
  output logic [OUT_BITS-1:0]  pm,
  output logic [OUT_BITS-1:0]  rm,
  output logic [OUT_BITS-1:0]  lm,
  output logic [OUT_BITS-1:0]  rp
);
  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int DEPTH = 1 << KW;
  localparam int EW = 2 * TIME_BITS + 2;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_UPD} st_t;
  st_t st_r;
  logic [KW-1:0] k_r;
  logic          init_r;

  // entry: long, repeat_valid, press_stamp, repeat_stamp
  logic          we;
  logic [EW-1:0] wdata, rdata;

  kdee_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(k_r), .wdata(wdata),
    .raddr(k_r), .rdata(rdata)
  );

  logic                 e_long, e_rv, p, dn, lng, rv, fire;
  logic [TIME_BITS-1:0] e_ps, e_rs, ps, rs, el_p, el_r;
  logic [31:0]          bpos;

  always_comb begin
    e_long = rdata[EW-1];
    e_rv   = rdata[EW-2];
    e_ps   = rdata[2*TIME_BITS-1:TIME_BITS];
    e_rs   = rdata[TIME_BITS-1:0];
    if (init_r) begin
      e_long = 1'b0; e_rv = 1'b0; e_ps = '0; e_rs = '0;
    end
    bpos = key_bit(32'(k_r));
    p = (bpos < SCAN_BITS) ? ~stable_word[bpos[$clog2(SCAN_BITS)-1:0]] : 1'b0;
    dn = down_q[k_r]; lng = e_long; ps = e_ps; rs = e_rs; rv = e_rv;
    if (edge_upd && p != dn) begin
      dn = p;
      if (p) begin
        ps = now; lng = 1'b0;
      end
    end
    el_p = now - ps;
    el_r = now - rs;
    fire = 1'b0;
    if (dn && (32'(k_r) < OUT_BITS) && rpt_en[k_r] &&
        el_p >= TIME_BITS'(rpt_delay_ms) &&
        (!rv || el_r >= TIME_BITS'(rpt_period_ms)))
      fire = 1'b1;
    if (fire) begin
      rs = now; rv = 1'b1;
    end
    wdata = {(lng | (dn && el_p >= TIME_BITS'(long_ms))), rv, ps, rs};
    we = (st_r == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; k_r <= '0; init_r <= 1'b1; done <= 1'b0;
      down_d <= '0; pm <= '0; rm <= '0; lm <= '0; rp <= '0;
    end else begin
      done <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start) begin
          st_r <= S_READ; k_r <= '0; down_d <= down_q;
          pm <= '0; rm <= '0; lm <= '0; rp <= '0;
        end
        S_READ: st_r <= S_UPD;
        S_UPD: begin
          down_d[k_r] <= dn;
          if (32'(k_r) < OUT_BITS) begin
            pm[k_r] <= edge_upd && p && !down_q[k_r];
            rm[k_r] <= edge_upd && !p && down_q[k_r];
            lm[k_r] <= dn && !lng && el_p >= TIME_BITS'(long_ms);
            rp[k_r] <= fire;
          end
          if (32'(k_r) == NUM_KEYS - 1) begin
            st_r <= S_IDLE; done <= 1'b1; init_r <= 1'b0;
          end else begin
            k_r <= k_r + 1'b1; st_r <= S_READ;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/keypad_debounce_event_engine.sv
// Channel | Dir | Beat payload
// in_     | in  | now_ms, scan_word (one tick)
// out_    | out | press/release/long/repeat/held masks, combo, held_count
// cfg_    | in  | index, data (register write)
// The result beat comes after the input beat once the per-key walk is through: the
// walk reads each key's entry from the memory, then updates it and writes it back.
// The next tick is taken in the cycle after the result beat is accepted, so ticks
// never overlap and output stalls hold off the next tick.
// Reset clears state and sets default timings; first-walk reads ignore the memory.
module keypad_debounce_event_engine
  import kdee_pkg::*;
#(
  parameter int NUM_KEYS  = NUM_KEYS_DEF,
  parameter int SCAN_BITS = SCAN_BITS_DEF,
  parameter int COMBO_MAX = COMBO_MAX_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  kdee_in_if.sink    in_ch,
  kdee_out_if.source out_ch,
  kdee_cfg_if.sink   cfg_ch
);
  logic [MS_BITS-1:0]  deb_r, long_r, rdl_r, rpr_r;
  logic [OUT_BITS-1:0] ren_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r <= 16'd20; long_r <= 16'd1000; rdl_r <= 16'd500; rpr_r <= 16'd100;
      ren_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_DEBOUNCE:  deb_r  <= cfg_ch.data[MS_BITS-1:0];
        REG_LONG:      long_r <= cfg_ch.data[MS_BITS-1:0];
        REG_RPT_DELAY: rdl_r  <= cfg_ch.data[MS_BITS-1:0];
        REG_RPT_PER:   rpr_r  <= cfg_ch.data[MS_BITS-1:0];
        REG_RPT_EN:    ren_r  <= cfg_ch.data[OUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [SCAN_BITS-1:0] cand_r, stab_r;
  logic [TIME_BITS-1:0] dstamp_r, now_r;
  logic [CNT_BITS-1:0]  held_r;
  logic [NUM_KEYS-1:0]  down_r, down_d;
  logic                 edge_r, start_r, done, work_r, ovalid_r;
  logic [OUT_BITS-1:0]  pm, rm, lm, rp;

  logic acc;
  assign in_ch.ready = !work_r && !ovalid_r;
  assign acc = in_ch.valid && in_ch.ready;

  logic [TIME_BITS-1:0] el;
  logic                 go, nc, ns;
  logic [SCAN_BITS-1:0] sc;
  always_comb begin
    sc = in_ch.scan_word[SCAN_BITS-1:0];
    el = in_ch.now_ms[TIME_BITS-1:0] - dstamp_r;
    go = el >= TIME_BITS'(deb_r);
    nc = go && (sc != cand_r);
    ns = go && !nc && (sc != stab_r);
  end

  kdee_keyseq #(.NUM_KEYS(NUM_KEYS), .SCAN_BITS(SCAN_BITS), .TIME_BITS(TIME_BITS)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start_r), .edge_upd(edge_r),
    .stable_word(stab_r), .now(now_r), .long_ms(long_r), .rpt_delay_ms(rdl_r),
    .rpt_period_ms(rpr_r), .rpt_en(ren_r), .down_q(down_r), .down_d(down_d),
    .done(done), .pm(pm), .rm(rm), .lm(lm), .rp(rp)
  );

  logic [CNT_BITS-1:0] cnt;
  logic [4:0]          first;
  always_comb begin
    cnt = '0;
    first = '0;
    for (int i = 0; i < NUM_KEYS; i++) cnt = cnt + CNT_BITS'(down_d[i]);
    for (int i = NUM_KEYS - 1; i >= 0; i--) if (down_d[i]) first = 5'(i + 1);
  end

  logic [CNT_BITS-1:0] held_v;
  assign held_v = edge_r ? cnt : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '1; stab_r <= '1; dstamp_r <= '0; held_r <= '0; down_r <= '0;
      edge_r <= 1'b0; start_r <= 1'b0; work_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (acc) begin
        now_r <= in_ch.now_ms[TIME_BITS-1:0];
        edge_r <= ns;
        start_r <= 1'b1; work_r <= 1'b1;
        if (nc) begin
          cand_r <= sc; dstamp_r <= in_ch.now_ms[TIME_BITS-1:0];
        end
        if (ns) stab_r <= sc;
      end
      if (done) begin
        work_r <= 1'b0; ovalid_r <= 1'b1;
        down_r <= down_d; held_r <= held_v;
        out_ch.press_mask <= pm; out_ch.release_mask <= rm;
        out_ch.long_mask <= lm; out_ch.repeat_mask <= rp;
        out_ch.held_count <= held_v;
        out_ch.held_mask <= OUT_BITS'(down_d);
        out_ch.combo_valid <= (held_v > 1) && (32'(held_v) <= COMBO_MAX);
        out_ch.combo_first_key <= ((held_v > 1) && (32'(held_v) <= COMBO_MAX)) ? first : '0;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = ovalid_r;
endmodule

// File: tb/sv/kdee_event_checker.sv
`timescale 1ns / 100ps
module kdee_event_checker
  import kdee_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  kdee_in_if         in_ch,
  kdee_out_if        out_ch,
  kdee_cfg_if        cfg_ch,
  output int         errors,
  output int         pending,
  output int         n_results,
  output int         n_long,
  output int         n_repeat,
  output int         n_combo
);
  typedef struct packed {
    logic [21:0] press;
    logic [21:0] rel;
    logic [21:0] long_ev;
    logic [21:0] rpt;
    logic        combo;
    logic [4:0]  first_key;
    logic [4:0]  held;
    logic [21:0] hmask;
  } key_events_t;

  key_events_t expected_events[$];

  logic [15:0] debounce_ms, long_ms, rpt_delay_ms, rpt_period_ms;
  logic [21:0] rpt_enable;
  logic [23:0] cand_word, stable_word;
  logic [31:0] db_stamp;
  logic [21:0] down, long_seen, rpt_armed;
  logic [31:0] press_at[22];
  logic [31:0] rpt_at[22];
  logic [4:0]  held_num;

  function automatic int scan_pos(int k);
    return (k / 8) * 8 + 7 - (k % 8);
  endfunction

  function automatic key_events_t debounce_tick(logic [31:0] now, logic [23:0] scan);
    key_events_t ev;
    logic p;
    ev = '0;
    if (now - db_stamp >= {16'd0, debounce_ms}) begin
      if (scan != cand_word) begin
        db_stamp = now;
        cand_word = scan;
      end else if (scan != stable_word) begin
        stable_word = scan;
        held_num = 0;
        for (int k = 0; k < 22; k++) begin
          p = !stable_word[scan_pos(k)];
          if (p != down[k]) begin
            down[k] = p;
            if (p) begin
              press_at[k] = now;
              long_seen[k] = 1'b0;
              ev.press[k] = 1'b1;
            end else begin
              ev.rel[k] = 1'b1;
            end
          end
          if (p) held_num++;
        end
      end
    end
    for (int k = 0; k < 22; k++)
      if (down[k] && !long_seen[k] && now - press_at[k] >= {16'd0, long_ms}) begin
        long_seen[k] = 1'b1;
        ev.long_ev[k] = 1'b1;
      end
    if (held_num > 1 && held_num <= 5) begin
      ev.combo = 1'b1;
      for (int k = 21; k >= 0; k--)
        if (down[k]) ev.first_key = 5'(k + 1);
    end
    for (int k = 0; k < 22; k++) begin
      if (down[k] && rpt_enable[k] && now - press_at[k] >= {16'd0, rpt_delay_ms}) begin
        // first repeat only needs the delay; later ones the period too
        if (!rpt_armed[k] || now - rpt_at[k] >= {16'd0, rpt_period_ms}) begin
          ev.rpt[k] = 1'b1;
          rpt_at[k] = now;
          rpt_armed[k] = 1'b1;
        end
      end
    end
    ev.held = held_num;
    ev.hmask = down;
    return ev;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h want %h", $realtime, field, got, want);
    errors++;
  endtask

  assign pending = expected_events.size();

  always @(posedge clk) begin
    key_events_t e;
    if (!rst_n) begin
      debounce_ms = 16'd20; long_ms = 16'd1000;
      rpt_delay_ms = 16'd500; rpt_period_ms = 16'd100; rpt_enable = '0;
      cand_word = '1; stable_word = '1; db_stamp = '0;
      down = '0; long_seen = '0; rpt_armed = '0; held_num = '0;
      for (int k = 0; k < 22; k++) begin
        press_at[k] = '0;
        rpt_at[k] = '0;
      end
      expected_events.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DEBOUNCE:  debounce_ms = cfg_ch.data[15:0];
          REG_LONG:      long_ms = cfg_ch.data[15:0];
          REG_RPT_DELAY: rpt_delay_ms = cfg_ch.data[15:0];
          REG_RPT_PER:   rpt_period_ms = cfg_ch.data[15:0];
          REG_RPT_EN:    rpt_enable = cfg_ch.data[21:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_events.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          e = expected_events.pop_front();
          if (out_ch.press_mask !== e.press) report("press_mask", out_ch.press_mask, e.press);
          if (out_ch.release_mask !== e.rel)
            report("release_mask", out_ch.release_mask, e.rel);
          if (out_ch.long_mask !== e.long_ev) report("long_mask", out_ch.long_mask, e.long_ev);
          if (out_ch.repeat_mask !== e.rpt) report("repeat_mask", out_ch.repeat_mask, e.rpt);
          if (out_ch.combo_valid !== e.combo)
            report("combo_valid", out_ch.combo_valid, e.combo);
          if (out_ch.combo_first_key !== e.first_key)
            report("combo_first_key", out_ch.combo_first_key, e.first_key);
          if (out_ch.held_count !== e.held) report("held_count", out_ch.held_count, e.held);
          if (out_ch.held_mask !== e.hmask) report("held_mask", out_ch.held_mask, e.hmask);
          if (e.long_ev != 0) n_long++;
          if (e.rpt != 0) n_repeat++;
          if (e.combo) n_combo++;
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_events.push_back(debounce_tick(in_ch.now_ms, in_ch.scan_word));
    end
  end

  initial begin
    errors = 0; n_results = 0; n_long = 0; n_repeat = 0; n_combo = 0;
  end
endmodule

// File: tb/sv/tb_keypad_debounce_event_engine.sv
`timescale 1ns / 100ps
module tb_keypad_debounce_event_engine;
  import kdee_pkg::*;

  logic clk;
  logic rst_n;
  logic quiet;
  int   errors, pending, n_results, n_long, n_repeat, n_combo;
  int   ticks_sent, stall_cnt;
  logic [31:0] now;
  logic [23:0] pattern;
  int   step_max;

  kdee_in_if  in_ch ();
  kdee_out_if out_ch ();
  kdee_cfg_if cfg_ch ();

  keypad_debounce_event_engine dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  kdee_event_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending), .n_results(n_results), .n_long(n_long),
    .n_repeat(n_repeat), .n_combo(n_combo)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_ch.ready <= 1'b1;
    end else if (out_ch.ready) begin
      if ($urandom_range(0, 5) == 0) out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == 20000) begin
        $display("keypad_debounce_event_engine: mismatch");
        $finish;
      end
    end
  end

  task automatic send_tick(logic [31:0] t, logic [23:0] scan);
    in_ch.valid <= 1'b1;
    in_ch.now_ms <= t;
    in_ch.scan_word <= scan;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
    if (!quiet && (ticks_sent % 200) < 140 && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(logic [31:0] db, logic [31:0] lp, logic [31:0] dl,
                            logic [31:0] per, logic [31:0] en);
    drain();
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_LONG, lp);
    write_reg(REG_RPT_DELAY, dl);
    write_reg(REG_RPT_PER, per);
    write_reg(REG_RPT_EN, en);
    write_reg(3'd5 + 3'($urandom_range(0, 2)), $urandom);
    step_max = db[15:0] + 40;
  endtask

  // held key patterns, bounce, and stray noise
  task automatic random_ticks(int n);
    int hold;
    logic [23:0] w;
    for (int i = 0; i < n; i += hold) begin
      hold = $urandom_range(1, 30);
      case ($urandom_range(0, 9))
        0: pattern = $urandom;
        1: pattern = '1;
        default: begin
          pattern = '1;
          repeat ($urandom_range(1, 6)) pattern[$urandom_range(0, 23)] = 1'b0;
        end
      endcase
      for (int j = 0; j < hold; j++) begin
        w = ($urandom_range(0, 11) == 0) ? 24'($urandom) : pattern;
        now += $urandom_range(0, step_max);
        send_tick(now, w);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    ticks_sent = 0;
    step_max = 60;
    in_ch.valid = 1'b0; in_ch.now_ms = '0; in_ch.scan_word = '1;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, extreme words, time wrap
    now = 32'd0;
    send_tick(now, 24'hFFFFFF);
    send_tick(32'd30, 24'h000000);
    send_tick(32'd60, 24'h000000);
    send_tick(32'd1100, 24'h000000);
    send_tick(32'hFFFF_FFFF, 24'hFFFFFF);
    send_tick(32'd40, 24'hFFFFFF);
    set_timing(0, 0, 0, 0, 32'hFFFF_FFFF);
    now = 32'hFFFF_FFF0;
    for (int k = 0; k < 6; k++) begin
      send_tick(now, 24'hFFFFFF ^ (24'h1 << (k * 4 + 3)));
      send_tick(now, 24'hFFFFFF ^ (24'h1 << (k * 4 + 3)));
      now += 5;
    end
    send_tick(now, 24'hFEFF7F);
    send_tick(now, 24'hFEFF7F);
    send_tick(now + 3, 24'hFFFFFF);
    send_tick(now + 3, 24'hFFFFFF);
    send_tick(32'hFFFF_FFFF, 24'h030000);
    send_tick(32'hFFFF_FFFF, 24'h030000);

    // random phases over several timing settings
    set_timing(0, 0, 0, 0, 32'hFFFF_FFFF);
    random_ticks(220);
    set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFFFF);
    random_ticks(150);
    set_timing(20, 1000, 500, 100, 0);
    random_ticks(220);
    for (int p = 0; p < 4; p++) begin
      set_timing($urandom_range(0, 30), $urandom_range(0, 300), $urandom_range(0, 200),
                 $urandom_range(0, 80), $urandom);
      random_ticks(220);
    end
    quiet = 1'b1;
    random_ticks(150);

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d ticks, %0d results: %0d with long press, %0d with repeat, %0d combo",
             ticks_sent, n_results, n_long, n_repeat, n_combo);
    if (errors == 0) begin
      $display("keypad_debounce_event_engine: match");
    end else begin
      $display("keypad_debounce_event_engine: mismatch");
    end
    $finish;
  end
endmodule
